// ===== hdl/lrca_pkg.sv =====
// ----------------------------------------------------------------------------
// lrca_pkg: shared types and constants for the labeled run confusion
// accumulator (state codes, unit operations, register indexes, reset values).
// ----------------------------------------------------------------------------
package lrca_pkg;

  localparam int WORD_W    = 32;
  localparam int THR_W     = 16;
  localparam int PROD_W    = WORD_W + THR_W;
  localparam int CFG_IDX_W = 3;
  localparam int BIN_W     = 2;
  localparam int LABEL_W   = 3;
  localparam int RAW_W     = 4;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OVERLAP_BASED     = 3'd0,
    CFG_OVERLAP_THRESHOLD = 3'd1,
    CFG_BIN_EDGE_ONE      = 3'd2,
    CFG_BIN_EDGE_TWO      = 3'd3,
    CFG_BIN_EDGE_THREE    = 3'd4
  } cfg_idx_t;

  localparam logic             RST_OVERLAP_BASED     = 1'b0;
  localparam logic [THR_W-1:0]  RST_OVERLAP_THRESHOLD = 16'd32768;
  localparam logic [WORD_W-1:0] RST_BIN_EDGE_ONE      = 32'd1000;
  localparam logic [WORD_W-1:0] RST_BIN_EDGE_TWO      = 32'd10000;
  localparam logic [WORD_W-1:0] RST_BIN_EDGE_THREE    = 32'd100000;

  localparam logic [BIN_W-1:0] LAST_BIN_STEP = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LEN,
    ST_BIN,
    ST_PROD,
    ST_EMIT_CMP,
    ST_EMIT_OUT,
    ST_UPD,
    ST_ACC_RD,
    ST_ACC_WR
  } state_t;

  typedef enum logic [1:0] {
    UOP_ADD,
    UOP_DIFF1,
    UOP_GT
  } unit_op_t;

  typedef struct packed {
    unit_op_t            op;
    logic [PROD_W-1:0]   a;
    logic [PROD_W-1:0]   b;
  } unit_req_t;

endpackage

// ===== hdl/labeled_run_confusion_accumulator.sv =====
// ----------------------------------------------------------------------------
// labeled_run_confusion_accumulator: per-run query label counts
// Splits the block stream into annotated runs per reference label and contig,
// sums block lengths per query label, and emits one word per column when a
// run closes or on a finish word.
// ----------------------------------------------------------------------------
// A word that closes a run computes the run length, steps through the bin
// edges, forms the threshold product, then compares and emits each column in
// turn (held while out_stall is high); every word then updates the run state,
// and an annotated word that is not a finish word also reads and writes its row entry.
// The shared unit and the single row RAM read port are reused by these steps;
// one item is worked on at a time.
// Reset (rst, synchronous): configuration registers return to defaults, the
// run state clears, and all row entries are invalidated at once by their valid bits.
module labeled_run_confusion_accumulator #(
  parameter int LABELS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [lrca_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lrca_pkg::WORD_W-1:0]          cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 op,
  input  logic [lrca_pkg::WORD_W-1:0]          start_req,
  input  logic [lrca_pkg::WORD_W-1:0]          stop,
  input  logic                                 new_contig,
  input  logic                                 in_annotation,
  input  logic signed [lrca_pkg::RAW_W-1:0]    ref_label,
  input  logic signed [lrca_pkg::RAW_W-1:0]    query_label,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [lrca_pkg::BIN_W-1:0]           bin_index,
  output logic [lrca_pkg::LABEL_W-1:0]         row_label,
  output logic [lrca_pkg::LABEL_W-1:0]         column,
  output logic [lrca_pkg::WORD_W-1:0]          amount,
  output logic                                 last
);

  localparam int IDX_W = $clog2(LABELS);
  localparam int LBL_W = lrca_pkg::LABEL_W;
  localparam int W     = lrca_pkg::WORD_W;
  localparam int TW    = lrca_pkg::THR_W;
  localparam logic [IDX_W-1:0] LAST_COL = IDX_W'(LABELS - 1);

  function automatic logic [IDX_W-1:0] map_label(input logic [lrca_pkg::RAW_W-1:0] raw);
    logic [IDX_W-1:0] res;
    if (raw[lrca_pkg::RAW_W-1]) begin
      res = LAST_COL;
    end else if (int'(raw) >= LABELS) begin
      res = LAST_COL;
    end else begin
      res = IDX_W'(raw[lrca_pkg::RAW_W-2:0]);
    end
    return res;
  endfunction

  lrca_pkg::state_t state, state_next;

  // configuration
  logic          ovl_based;
  logic [TW-1:0] ovl_thr;
  logic [W-1:0]  edge_one, edge_two, edge_three;

  // stream state
  logic [W-1:0]      run_start;
  logic [W-1:0]      prev_end;
  logic [IDX_W-1:0]  prev_label;
  logic              prev_valid;
  logic              prev_annot;
  logic [LABELS-1:0] row_valid;

  // latched item
  logic             it_op;
  logic [W-1:0]     it_start, it_stop;
  logic             it_contig, it_cur;
  logic [IDX_W-1:0] it_ref, it_qry;

  // working registers
  logic [W-1:0]                 run_len, blen;
  logic [lrca_pkg::PROD_W-1:0]  prod;
  logic [lrca_pkg::BIN_W-1:0]   bin_cnt, bin_step;
  logic [IDX_W-1:0]             col;
  logic                         any_hit;
  logic                         rd_valid;

  // RAM and unit
  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [W-1:0]     ram_wdata, ram_rdata;
  lrca_pkg::unit_req_t req;
  logic [W-1:0]     unit_sum;
  logic             unit_gt;

  logic             in_accept;
  logic [IDX_W-1:0] ref_now;
  logic             ref_changed_now, emit_now;
  logic             ref_changed_upd, clr_idle, clr_start;
  logic [W-1:0]     cnt_masked, edge_sel;

  lrca_ram #(.WIDTH(W), .DEPTH(LABELS)) u_row_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lrca_unit u_unit (
    .req (req),
    .sum (unit_sum),
    .gt  (unit_gt)
  );

  assign in_stall  = (state != lrca_pkg::ST_IDLE);
  assign out_valid = (state == lrca_pkg::ST_EMIT_OUT);
  assign in_accept = in_valid && !in_stall;

  assign ref_now         = map_label(ref_label);
  assign ref_changed_now = !prev_valid || (ref_now != prev_label);
  assign emit_now = op ? (prev_annot && prev_valid)
                       : (prev_valid && prev_annot &&
                          (ref_changed_now || new_contig || !in_annotation));

  assign ref_changed_upd = !prev_valid || (it_ref != prev_label);
  assign clr_idle  = !it_cur && (it_contig || prev_annot);
  assign clr_start = it_cur && ((prev_annot && ref_changed_upd) || it_contig || !prev_annot);

  // never-written or cleared entries read as zero
  assign cnt_masked = rd_valid ? ram_rdata : '0;

  always_comb begin
    case (bin_step)
      2'd0:    edge_sel = edge_one;
      2'd1:    edge_sel = edge_two;
      default: edge_sel = edge_three;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      lrca_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_next = emit_now ? lrca_pkg::ST_LEN : lrca_pkg::ST_UPD;
        end
      end
      lrca_pkg::ST_LEN:  state_next = lrca_pkg::ST_BIN;
      lrca_pkg::ST_BIN: begin
        if (bin_step == lrca_pkg::LAST_BIN_STEP) begin
          state_next = lrca_pkg::ST_PROD;
        end
      end
      lrca_pkg::ST_PROD:     state_next = lrca_pkg::ST_EMIT_CMP;
      lrca_pkg::ST_EMIT_CMP: state_next = lrca_pkg::ST_EMIT_OUT;
      lrca_pkg::ST_EMIT_OUT: begin
        if (!out_stall) begin
          state_next = (col == LAST_COL) ? lrca_pkg::ST_UPD : lrca_pkg::ST_EMIT_CMP;
        end
      end
      lrca_pkg::ST_UPD: begin
        state_next = (!it_op && it_cur) ? lrca_pkg::ST_ACC_RD : lrca_pkg::ST_IDLE;
      end
      lrca_pkg::ST_ACC_RD: state_next = lrca_pkg::ST_ACC_WR;
      lrca_pkg::ST_ACC_WR: state_next = lrca_pkg::ST_IDLE;
      default:             state_next = lrca_pkg::ST_IDLE;
    endcase
  end

  // unit operands and RAM controls
  always_comb begin
    req.op    = lrca_pkg::UOP_ADD;
    req.a     = '0;
    req.b     = '0;
    ram_re    = 1'b0;
    ram_raddr = col;
    ram_we    = 1'b0;
    ram_waddr = it_qry;
    ram_wdata = unit_sum;
    unique case (state)
      lrca_pkg::ST_LEN: begin
        req.op = lrca_pkg::UOP_DIFF1;
        req.a  = {{TW{1'b0}}, prev_end};
        req.b  = {{TW{1'b0}}, run_start};
      end
      lrca_pkg::ST_BIN: begin
        req.op = lrca_pkg::UOP_GT;
        req.a  = {{TW{1'b0}}, edge_sel};
        req.b  = {{TW{1'b0}}, run_len};
      end
      lrca_pkg::ST_PROD: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
      end
      lrca_pkg::ST_EMIT_CMP: begin
        // count / length > thr / 2^16, as count * 2^16 > thr * length
        req.op = lrca_pkg::UOP_GT;
        req.a  = {cnt_masked, {TW{1'b0}}};
        req.b  = prod;
      end
      lrca_pkg::ST_EMIT_OUT: begin
        if (!out_stall && (col != LAST_COL)) begin
          ram_re    = 1'b1;
          ram_raddr = col + {{(IDX_W-1){1'b0}}, 1'b1};
        end
      end
      lrca_pkg::ST_UPD: begin
        req.op = lrca_pkg::UOP_DIFF1;
        req.a  = {{TW{1'b0}}, it_stop};
        req.b  = {{TW{1'b0}}, it_start};
      end
      lrca_pkg::ST_ACC_RD: begin
        ram_re    = 1'b1;
        ram_raddr = it_qry;
      end
      lrca_pkg::ST_ACC_WR: begin
        req.op = lrca_pkg::UOP_ADD;
        req.a  = {{TW{1'b0}}, cnt_masked};
        req.b  = {{TW{1'b0}}, blen};
        ram_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // control, configuration and stream state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= lrca_pkg::ST_IDLE;
      ovl_based  <= lrca_pkg::RST_OVERLAP_BASED;
      ovl_thr    <= lrca_pkg::RST_OVERLAP_THRESHOLD;
      edge_one   <= lrca_pkg::RST_BIN_EDGE_ONE;
      edge_two   <= lrca_pkg::RST_BIN_EDGE_TWO;
      edge_three <= lrca_pkg::RST_BIN_EDGE_THREE;
      run_start  <= '0;
      prev_end   <= '0;
      prev_label <= '0;
      prev_valid <= 1'b0;
      prev_annot <= 1'b0;
      row_valid  <= '0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        unique case (cfg_index)
          lrca_pkg::CFG_OVERLAP_BASED:     ovl_based  <= cfg_data[0];
          lrca_pkg::CFG_OVERLAP_THRESHOLD: ovl_thr    <= cfg_data[TW-1:0];
          lrca_pkg::CFG_BIN_EDGE_ONE:      edge_one   <= cfg_data;
          lrca_pkg::CFG_BIN_EDGE_TWO:      edge_two   <= cfg_data;
          lrca_pkg::CFG_BIN_EDGE_THREE:    edge_three <= cfg_data;
          default: begin
          end
        endcase
      end
      if (state == lrca_pkg::ST_UPD) begin
        if (it_op) begin
          // finish: drop the whole stream
          run_start  <= '0;
          prev_end   <= '0;
          prev_label <= '0;
          prev_valid <= 1'b0;
          prev_annot <= 1'b0;
          row_valid  <= '0;
        end else begin
          if (clr_start) begin
            run_start <= it_start;
            row_valid <= '0;
          end else if (clr_idle) begin
            run_start <= '0;
            row_valid <= '0;
          end
          prev_annot <= it_cur;
          prev_label <= it_ref;
          prev_valid <= 1'b1;
          prev_end   <= it_stop;
        end
      end
      if (state == lrca_pkg::ST_ACC_WR) begin
        row_valid[it_qry] <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (ram_re) begin
      rd_valid <= row_valid[ram_raddr];
    end
    case (state)
      lrca_pkg::ST_IDLE: begin
        if (in_accept) begin
          it_op     <= op;
          it_start  <= start_req;
          it_stop   <= stop;
          it_contig <= new_contig;
          it_cur    <= in_annotation;
          it_ref    <= ref_now;
          it_qry    <= map_label(query_label);
        end
      end
      lrca_pkg::ST_LEN: begin
        run_len  <= unit_sum;
        bin_step <= '0;
        bin_cnt  <= '0;
      end
      lrca_pkg::ST_BIN: begin
        if (!unit_gt) begin
          bin_cnt <= bin_cnt + 2'd1;
        end
        bin_step <= bin_step + 2'd1;
      end
      lrca_pkg::ST_PROD: begin
        prod    <= {{W{1'b0}}, ovl_thr} * {{TW{1'b0}}, run_len};
        col     <= '0;
        any_hit <= 1'b0;
      end
      lrca_pkg::ST_EMIT_CMP: begin
        bin_index <= bin_cnt;
        row_label <= LBL_W'(prev_label);
        column    <= LBL_W'(col);
        last      <= (col == LAST_COL);
        if (ovl_based) begin
          // no hit anywhere in the row: force the last column
          if (col == LAST_COL) begin
            amount <= {{(W-1){1'b0}}, unit_gt || !any_hit};
          end else begin
            amount <= {{(W-1){1'b0}}, unit_gt};
          end
          any_hit <= any_hit || unit_gt;
        end else begin
          amount <= cnt_masked;
        end
      end
      lrca_pkg::ST_EMIT_OUT: begin
        if (!out_stall) begin
          col <= col + {{(IDX_W-1){1'b0}}, 1'b1};
        end
      end
      lrca_pkg::ST_UPD: begin
        blen <= unit_sum;
      end
      default: begin
      end
    endcase
  end

  a_no_accept_while_emitting: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input accepted while a row is being emitted");

  a_last_on_final_column: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> (column == LBL_W'(LABELS - 1)))
    else $error("last flag on a column other than the final one");

  a_row_ends_after_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && last) |=> !out_valid)
    else $error("output still valid after the final column was taken");

endmodule

// ===== hdl/lrca_ram.sv =====
// ----------------------------------------------------------------------------
// lrca_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lrca_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/lrca_unit.sv =====
// ----------------------------------------------------------------------------
// lrca_unit: shared arithmetic unit
// One adder/subtractor and one wide magnitude compare, reused by the
// sequencer for run and block lengths, bin edges, overlap test and accumulation.
// ----------------------------------------------------------------------------
module lrca_unit (
  input  lrca_pkg::unit_req_t            req,
  output logic [lrca_pkg::WORD_W-1:0]    sum,
  output logic                           gt
);

  always_comb begin
    unique case (req.op)
      lrca_pkg::UOP_ADD:   sum = req.a[lrca_pkg::WORD_W-1:0] + req.b[lrca_pkg::WORD_W-1:0];
      lrca_pkg::UOP_DIFF1: sum = req.a[lrca_pkg::WORD_W-1:0] - req.b[lrca_pkg::WORD_W-1:0]
                                 + {{(lrca_pkg::WORD_W-1){1'b0}}, 1'b1};
      lrca_pkg::UOP_GT:    sum = '0;
      default:             sum = '0;
    endcase
  end

  assign gt = (req.op == lrca_pkg::UOP_GT) && (req.a > req.b);

endmodule
